@@ design/hvf_pkg.sv @@
// ----------------------------------------------------------------------------
// hvf_pkg: shared types and constants of the visual follow controller
// Field widths, command and status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package hvf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int IMAGE_WIDTH = 640;
  localparam int HALF_WIDTH  = IMAGE_WIDTH / 2;
  localparam int MSG_WORDS   = 12;
  localparam int WC_W        = 4;

  localparam int WORD_W  = 32;
  localparam int NUM_W   = 50;   // projected numerator / denominator
  localparam int QMAG_W  = 37;   // quotient magnitude, up to 2^36
  localparam int Q_W     = 38;   // signed quotient
  localparam int DIV_STEPS = 36;
  localparam int XLIM_LOG2 = 20;
  localparam int CNT_W   = 6;
  localparam int ACC_W   = 40;
  localparam int X_W     = 22;
  localparam int XDIFF_W = 23;
  localparam int ANG_W   = 40;
  localparam int LDIFF_W = 34;
  localparam int LPROD_W = 53;
  localparam int LIN_W   = 37;
  localparam int MUL_W   = 35;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int AOUT_W  = 20;
  localparam int LOUT_W  = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_LEFT  = 2'd0,
    CMD_RIGHT = 2'd1,
    CMD_WORD  = 2'd2,
    CMD_EMPTY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FOLLOW = 2'd0,
    ST_OTHER  = 2'd1,
    ST_SHORT  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_ID   = 3'd0,
    REG_ANG_GAIN    = 3'd1,
    REG_MIN_ANG     = 3'd2,
    REG_MAX_ANG     = 3'd3,
    REG_DESIRED     = 3'd4,
    REG_LIN_GAIN    = 3'd5,
    REG_MIN_LIN     = 3'd6,
    REG_MAX_LIN     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  target_id;
    logic [16:0] ang_gain;
    logic [18:0] min_angular;
    logic [18:0] max_angular;
    logic [22:0] desired_distance;
    logic [18:0] lin_gain;
    logic [17:0] min_linear;
    logic [17:0] max_linear;
  } cfg_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_MUL_A,
    C_MUL_B,
    C_MUL_C,
    C_MUL_D,
    C_CORNER,
    C_DIV_START,
    C_DIV_WAIT,
    C_MEAN,
    C_MUL_ANG,
    C_MUL_LIN,
    C_SCALE,
    C_FINISH
  } core_state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic signed [Q_W-1:0] quo;
  } div_stat_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

@@ design/homography_visual_follow_controller_unit.sv @@
// ----------------------------------------------------------------------------
// homography_visual_follow_controller_unit: visual follow velocity controller
// Latches ranges, collects object message words and issues one command.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tuser carries the command (left range, right range,
//   message word, empty message), s_tdata the Q16.16 value and s_tlast
//   marks the last word of an object message.
//   Range commands and non-final words are absorbed without a result.
//   An empty message, a message with another id or a short message yields a
//   zero-velocity result with its status in the cycle after the transaction.
//   A full message for the target id starts the sequencer: four corner
//   products on the shared multiplier, four 36-step divider runs, the mean,
//   two gain products and the clamp, then hands its result over. A divider
//   run ends without iterating for a corner whose divisor is zero or whose
//   projection saturates. s_tready stays low while the sequencer runs.
//   Results wait in an output register; while the receiver stalls, no new
//   transaction is accepted, and the sequencer holds its result.
//   Configuration writes take effect at the next edge.
//   Reset clears ranges, word count and registers to their defaults.
// ----------------------------------------------------------------------------
module homography_visual_follow_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [hvf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hvf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] command
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [19:0] angular_velocity, [38:20] linear_velocity
  output logic [1:0]  m_tuser    // [1:0] status
);
  import hvf_pkg::*;

  cfg_t                    cfg;
  word_t                   left_range, right_range;
  word_t                   msg [MSG_WORDS];
  logic [WC_W-1:0]         word_count;
  logic signed [AOUT_W-1:0] out_ang;
  logic signed [LOUT_W-1:0] out_lin;
  status_t                 out_status;

  core_ctrl_t              core_ctrl;
  core_stat_t              core_stat;
  logic signed [AOUT_W-1:0] core_ang;
  logic signed [LOUT_W-1:0] core_lin;

  logic                    out_free;
  logic                    accept;
  cmd_t                    cmd;
  word_t                   word0;
  logic                    wc_full;
  logic [WC_W-1:0]         count_after;
  logic signed [16:0]      id_val;
  logic                    id_match;

  assign out_free = !m_tvalid || m_tready;
  // hold input while the sequencer result moves into the output register
  assign s_tready = !core_stat.busy && !core_stat.done && out_free;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser);

  always_comb begin
    wc_full     = word_count >= WC_W'(MSG_WORDS);
    count_after = wc_full ? word_count : word_count + WC_W'(1);
    word0       = (word_count == '0) ? $signed(s_tdata) : msg[0];
    // integer part of word 0, truncated toward zero
    id_val = 17'($signed(word0[WORD_W-1:FRAC_BITS]));
    if (word0[WORD_W-1] && (word0[FRAC_BITS-1:0] != '0)) id_val = id_val + 17'sd1;
    id_match = (id_val == $signed({9'b0, cfg.target_id}));
    core_ctrl.start = accept && (cmd == CMD_WORD) && s_tlast && id_match
                      && (count_after == WC_W'(MSG_WORDS));
    core_ctrl.out_free = out_free;
  end

  hvf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (core_ctrl),
    .cfg         (cfg),
    .msg         (msg),
    .left_range  (left_range),
    .right_range (right_range),
    .stat        (core_stat),
    .ang_out     (core_ang),
    .lin_out     (core_lin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_id        <= 8'd3;
      cfg.ang_gain         <= 17'd131;
      cfg.min_angular      <= 19'd9830;
      cfg.max_angular      <= 19'd32768;
      cfg.desired_distance <= 23'd39322;
      cfg.lin_gain         <= 19'd26214;
      cfg.min_linear       <= 18'd3277;
      cfg.max_linear       <= 18'd26214;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_ID: cfg.target_id        <= cfg_data[7:0];
        REG_ANG_GAIN:  cfg.ang_gain         <= cfg_data[16:0];
        REG_MIN_ANG:   cfg.min_angular      <= cfg_data[18:0];
        REG_MAX_ANG:   cfg.max_angular      <= cfg_data[18:0];
        REG_DESIRED:   cfg.desired_distance <= cfg_data[22:0];
        REG_LIN_GAIN:  cfg.lin_gain         <= cfg_data[18:0];
        REG_MIN_LIN:   cfg.min_linear       <= cfg_data[17:0];
        REG_MAX_LIN:   cfg.max_linear       <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_WORD) && !wc_full) msg[word_count] <= $signed(s_tdata);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_range  <= '0;
      right_range <= '0;
      word_count  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (core_stat.done) begin
        m_tvalid   <= 1'b1;
        out_ang    <= core_ang;
        out_lin    <= core_lin;
        out_status <= ST_FOLLOW;
      end
      if (accept) begin
        unique case (cmd)
          CMD_LEFT:  left_range  <= $signed(s_tdata);
          CMD_RIGHT: right_range <= $signed(s_tdata);
          CMD_EMPTY: begin
            word_count <= '0;
            m_tvalid   <= 1'b1;
            out_ang    <= '0;
            out_lin    <= '0;
            out_status <= ST_OTHER;
          end
          CMD_WORD: begin
            word_count <= count_after;
            if (s_tlast) begin
              word_count <= '0;
              if (!id_match) begin
                m_tvalid   <= 1'b1;
                out_ang    <= '0;
                out_lin    <= '0;
                out_status <= ST_OTHER;
              end else if (count_after != WC_W'(MSG_WORDS)) begin
                m_tvalid   <= 1'b1;
                out_ang    <= '0;
                out_lin    <= '0;
                out_status <= ST_SHORT;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign m_tdata = {1'b0, out_lin, out_ang};
  assign m_tuser = out_status;

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    core_stat.busy |-> !s_tready)
    else $error("input accepted while sequencer busy");

  a_done_needs_room: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> $past(out_free))
    else $error("sequencer result overwrote a pending output");

  a_word_count_range: assert property (@(posedge clk) disable iff (rst)
    word_count <= WC_W'(MSG_WORDS))
    else $error("word count beyond message length");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    core_ctrl.start |=> (core_stat.busy && !s_tready))
    else $error("sequencer did not start");

endmodule

@@ design/hvf_divider.sv @@
// ----------------------------------------------------------------------------
// hvf_divider: serial restoring divider for projected x
// Signed num/den with FRAC_BITS fraction bits, truncated toward zero,
// saturated at 2^20 pixels, zero for a zero divisor. One bit per cycle.
// ----------------------------------------------------------------------------
module hvf_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  hvf_pkg::div_ctrl_t                ctrl,
  input  logic signed [hvf_pkg::NUM_W-1:0]  num,
  input  logic signed [hvf_pkg::NUM_W-1:0]  den,
  output hvf_pkg::div_stat_t                stat
);
  import hvf_pkg::*;

  logic                  busy;
  logic                  done;
  logic signed [Q_W-1:0] quo;
  logic [CNT_W-1:0]      cnt;
  logic [NUM_W-1:0]      rem;
  logic [DIV_STEPS-1:0]  sh;
  logic [QMAG_W-1:0]     q;
  logic                  neg;

  // divisor magnitude held for the run
  logic [NUM_W-1:0] ud_r;

  logic [NUM_W-1:0]               un, ud;
  logic                           ovf;
  logic                           sign_in;
  logic [NUM_W:0]                 trial;
  logic                           take;
  logic [QMAG_W-1:0]              q_next;

  localparam logic [QMAG_W-1:0] SAT_MAG = QMAG_W'(1) << DIV_STEPS;

  always_comb begin
    un      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    ud      = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
    sign_in = num[NUM_W-1] ^ den[NUM_W-1];
    ovf     = {{XLIM_LOG2{1'b0}}, un} >= {ud, {XLIM_LOG2{1'b0}}};
    trial   = {rem, sh[DIV_STEPS-1]};
    take    = trial >= {1'b0, ud_r};
    q_next  = {q[QMAG_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        neg <= sign_in;
        if (den == '0) begin
          quo  <= '0;
          done <= 1'b1;
        end else if (ovf) begin
          quo  <= sign_in ? -$signed({1'b0, SAT_MAG}) : $signed({1'b0, SAT_MAG});
          done <= 1'b1;
        end else begin
          rem  <= {{XLIM_LOG2{1'b0}}, un[NUM_W-1:XLIM_LOG2]};
          sh   <= {un[XLIM_LOG2-1:0], {FRAC_BITS{1'b0}}};
          ud_r <= ud;
          q    <= '0;
          cnt  <= CNT_W'(DIV_STEPS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= take ? NUM_W'(trial - {1'b0, ud_r}) : trial[NUM_W-1:0];
        sh  <= {sh[DIV_STEPS-2:0], 1'b0};
        q   <= q_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quo  = quo;

endmodule

@@ design/hvf_core.sv @@
// ----------------------------------------------------------------------------
// hvf_core: projection and control law sequencer
// Shares one signed multiplier over corner products and both gains, runs
// the divider once per corner, then applies deadband and clamping.
// ----------------------------------------------------------------------------
module hvf_core (
  input  logic                          clk,
  input  logic                          rst,
  input  hvf_pkg::core_ctrl_t           ctrl,
  input  hvf_pkg::cfg_t                 cfg,
  input  hvf_pkg::word_t                msg [hvf_pkg::MSG_WORDS],
  input  hvf_pkg::word_t                left_range,
  input  hvf_pkg::word_t                right_range,
  output hvf_pkg::core_stat_t           stat,
  output logic signed [hvf_pkg::AOUT_W-1:0] ang_out,
  output logic signed [hvf_pkg::LOUT_W-1:0] lin_out
);
  import hvf_pkg::*;

  core_state_t state, state_next;

  logic signed [NUM_W-1:0]   pa, pb, pc, pd;
  logic signed [NUM_W-1:0]   num_r, den_r;
  logic [1:0]                corner;
  logic signed [ACC_W-1:0]   acc;
  logic signed [XDIFF_W-1:0] xdiff;
  logic signed [LDIFF_W-1:0] ldiff;
  logic signed [ANG_W-1:0]   ang_r;
  logic signed [LPROD_W-1:0] lprod;
  logic signed [LIN_W-1:0]   lin_r;
  logic                      done;

  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [NUM_W-1:0]   prod_fs;
  logic signed [X_W-1:0]     x_mean;
  logic signed [LIN_W-1:0]   lin_fl;
  logic [ANG_W-1:0]          aabs;
  logic [LIN_W-1:0]          labs;
  div_ctrl_t                 div_ctrl;
  div_stat_t                 div_stat;

  hvf_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .num  (num_r),
    .den  (den_r),
    .stat (div_stat)
  );

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      C_MUL_A: begin
        op_a = MUL_W'(msg[3]);
        op_b = MUL_W'(msg[1]);
      end
      C_MUL_B: begin
        op_a = MUL_W'(msg[6]);
        op_b = MUL_W'(msg[2]);
      end
      C_MUL_C: begin
        op_a = MUL_W'(msg[5]);
        op_b = MUL_W'(msg[1]);
      end
      C_MUL_D: begin
        op_a = MUL_W'(msg[8]);
        op_b = MUL_W'(msg[2]);
      end
      C_MUL_ANG: begin
        op_a = $signed({{(MUL_W-17){1'b0}}, cfg.ang_gain});
        op_b = MUL_W'(xdiff);
      end
      C_MUL_LIN: begin
        op_a = $signed({{(MUL_W-19){1'b0}}, cfg.lin_gain});
        op_b = MUL_W'(ldiff);
      end
      default: ;
    endcase
    prod    = op_a * op_b;
    // floor to FRAC_BITS of a 32 x 32 product
    prod_fs = NUM_W'($signed(prod[63:FRAC_BITS]));
  end

  always_comb begin
    x_mean = acc[ACC_W-1:ACC_W-X_W];
    if (acc[ACC_W-1] && (acc[ACC_W-X_W-1:0] != '0)) x_mean = x_mean + X_W'(1);
    lin_fl = LIN_W'($signed(lprod[LPROD_W-1:FRAC_BITS+1]));
    if (lprod[LPROD_W-1] && (lprod[FRAC_BITS:0] != '0)) lin_fl = lin_fl + LIN_W'(1);
    aabs = ang_r[ANG_W-1] ? ANG_W'(-ang_r) : ANG_W'(ang_r);
    labs = lin_r[LIN_W-1] ? LIN_W'(-lin_r) : LIN_W'(lin_r);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next     = state;
    div_ctrl.start = 1'b0;
    unique case (state)
      C_IDLE:      if (ctrl.start) state_next = C_MUL_A;
      C_MUL_A:     state_next = C_MUL_B;
      C_MUL_B:     state_next = C_MUL_C;
      C_MUL_C:     state_next = C_MUL_D;
      C_MUL_D:     state_next = C_CORNER;
      C_CORNER:    state_next = C_DIV_START;
      C_DIV_START: begin
        div_ctrl.start = 1'b1;
        state_next     = C_DIV_WAIT;
      end
      C_DIV_WAIT: begin
        if (div_stat.done) state_next = (corner == 2'd3) ? C_MEAN : C_CORNER;
      end
      C_MEAN:      state_next = C_MUL_ANG;
      C_MUL_ANG:   state_next = C_MUL_LIN;
      C_MUL_LIN:   state_next = C_SCALE;
      C_SCALE:     state_next = C_FINISH;
      C_FINISH:    if (ctrl.out_free) state_next = C_IDLE;
      default:     state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          acc    <= '0;
          corner <= '0;
        end
        C_MUL_A: pa <= prod_fs;
        C_MUL_B: pb <= prod_fs;
        C_MUL_C: pc <= prod_fs;
        C_MUL_D: pd <= prod_fs;
        C_CORNER: begin
          // corner bit 0 selects x = width, bit 1 selects y = height
          num_r <= NUM_W'(msg[9])  + (corner[0] ? pa : '0) + (corner[1] ? pb : '0);
          den_r <= NUM_W'(msg[11]) + (corner[0] ? pc : '0) + (corner[1] ? pd : '0);
        end
        C_DIV_WAIT: begin
          if (div_stat.done) begin
            acc    <= acc + ACC_W'($signed(div_stat.quo));
            corner <= corner + 2'd1;
          end
        end
        C_MEAN: begin
          xdiff <= XDIFF_W'(HALF_WIDTH) - XDIFF_W'(x_mean);
          ldiff <= LDIFF_W'(left_range) + LDIFF_W'(right_range)
                   - $signed({{(LDIFF_W-24){1'b0}}, cfg.desired_distance, 1'b0});
        end
        C_MUL_ANG: ang_r <= ANG_W'(prod);
        C_MUL_LIN: lprod <= LPROD_W'(prod);
        C_SCALE:   lin_r <= lin_fl;
        C_FINISH: begin
          if (ctrl.out_free) begin
            done    <= 1'b1;
            ang_out <= '0;
            lin_out <= '0;
            if (aabs >= ANG_W'(cfg.min_angular)) begin
              if (aabs > ANG_W'(cfg.max_angular))
                ang_out <= ang_r[ANG_W-1] ? AOUT_W'(0) - AOUT_W'(cfg.max_angular)
                                          : AOUT_W'(cfg.max_angular);
              else
                ang_out <= ang_r[AOUT_W-1:0];
            end else if (labs >= LIN_W'(cfg.min_linear)) begin
              if (labs > LIN_W'(cfg.max_linear))
                lin_out <= lin_r[LIN_W-1] ? LOUT_W'(0) - LOUT_W'(cfg.max_linear)
                                          : LOUT_W'(cfg.max_linear);
              else
                lin_out <= lin_r[LOUT_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.busy = (state != C_IDLE);
  assign stat.done = done;

endmodule

@@ bench/homography_visual_follow_controller_unit_test.sv @@
// ----------------------------------------------------------------------------
// homography_visual_follow_controller_unit_test: regression bench
// Streams range readings and object messages into the follow controller,
// predicts each velocity command and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module homography_visual_follow_controller_unit_test;
  import hvf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] value;
    logic        last;
  } stream_item_t;

  typedef struct {
    logic signed [19:0] ang;
    logic signed [18:0] lin;
    status_t            status;
  } velocity_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  stream_item_t  pending_items[$];
  velocity_cmd_t expected_cmds[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;

  // controller state as predicted
  longint tgt_id, ang_gain, min_ang, max_ang, desired, lin_gain, min_lin, max_lin;
  longint left_rng, right_rng;
  longint msg_w[MSG_WORDS];
  int     wcount;

  homography_visual_follow_controller_unit i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint divide_x(longint num, longint den);
    longint unsigned un, ud, qi, r, frac, mag;
    bit neg;
    if (den == 0) return 0;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    qi = un / ud;
    if (qi >= (64'd1 << XLIM_LOG2)) begin
      mag = 64'd1 << (XLIM_LOG2 + FRAC_BITS);
    end else begin
      r = un % ud;
      frac = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= ud) begin
          r = r - ud;
          frac = frac | 1;
        end
      end
      mag = (qi << FRAC_BITS) | frac;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint corner_x(longint px, longint py);
    longint num, den;
    num = ((msg_w[3] * px) >>> FRAC_BITS) + ((msg_w[6] * py) >>> FRAC_BITS) + msg_w[9];
    den = ((msg_w[5] * px) >>> FRAC_BITS) + ((msg_w[8] * py) >>> FRAC_BITS) + msg_w[11];
    return divide_x(num, den);
  endfunction

  function automatic status_t steer(output longint ang_o, output longint lin_o);
    longint id, sum, x, ang, lin, aabs, labs;
    ang_o = 0;
    lin_o = 0;
    id = msg_w[0] / (64'sd1 <<< FRAC_BITS);
    if (id != tgt_id) return ST_OTHER;
    if (wcount < MSG_WORDS) return ST_SHORT;
    sum = corner_x(0, 0) + corner_x(msg_w[1], 0) + corner_x(0, msg_w[2])
        + corner_x(msg_w[1], msg_w[2]);
    x = sum / (64'sd4 <<< FRAC_BITS);
    ang = ang_gain * (HALF_WIDTH - x);
    lin = lin_gain * (left_rng + right_rng - 2 * desired);
    lin = lin / (64'sd2 <<< FRAC_BITS);
    aabs = ang < 0 ? -ang : ang;
    labs = lin < 0 ? -lin : lin;
    if (aabs >= min_ang)
      ang_o = ang > max_ang ? max_ang : (ang < -max_ang ? -max_ang : ang);
    else if (labs >= min_lin)
      lin_o = lin > max_lin ? max_lin : (lin < -max_lin ? -max_lin : lin);
    return ST_FOLLOW;
  endfunction

  // advance the predicted state by one accepted transaction
  function automatic void absorb_item(stream_item_t it);
    velocity_cmd_t vc;
    longint a, l;
    longint v;
    v = longint'(signed'(it.value));
    a = 0;
    l = 0;
    case (it.cmd)
      CMD_LEFT: left_rng = v;
      CMD_RIGHT: right_rng = v;
      CMD_EMPTY: begin
        wcount = 0;
        vc.status = ST_OTHER;
        vc.ang = '0;
        vc.lin = '0;
        expected_cmds.insert(expected_cmds.size(), vc);
      end
      default: begin
        if (wcount < MSG_WORDS) begin
          msg_w[wcount] = v;
          wcount++;
        end
        if (it.last) begin
          vc.status = steer(a, l);
          wcount = 0;
          vc.ang = a[19:0];
          vc.lin = l[18:0];
          expected_cmds.insert(expected_cmds.size(), vc);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    stream_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.cmd = cmd_t'(s_tuser);
        it.value = s_tdata;
        it.last = s_tlast;
        absorb_item(it);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && (no_gaps || $urandom_range(99) >= 21)) begin
          it = pending_items.pop_front();
          s_tuser <= it.cmd;
          s_tdata <= it.value;
          s_tlast <= it.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    velocity_cmd_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected command: ang %h lin %h status %0d",
                     m_tdata[19:0], m_tdata[38:20], m_tuser);
        end else begin
          want = expected_cmds.pop_front();
          if (m_tdata[19:0] !== want.ang || m_tdata[38:20] !== want.lin ||
              m_tuser !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("command mismatch: expected ang %h lin %h status %0d, got %h %h %0d",
                       want.ang, want.lin, want.status,
                       m_tdata[19:0], m_tdata[38:20], m_tuser);
          end
        end
      end
      m_tready <= no_gaps || $urandom_range(99) >= 21;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("homography_visual_follow_controller_unit regression: fail");
      $finish;
    end
  end

  task automatic push(cmd_t c, logic [31:0] v, logic lst);
    stream_item_t it;
    it.cmd = c;
    it.value = v;
    it.last = lst;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    case (idx)
      REG_TARGET_ID: tgt_id   = data & 32'hFF;
      REG_ANG_GAIN:  ang_gain = data & 32'h1FFFF;
      REG_MIN_ANG:   min_ang  = data & 32'h7FFFF;
      REG_MAX_ANG:   max_ang  = data & 32'h7FFFF;
      REG_DESIRED:   desired  = data & 32'h7FFFFF;
      REG_LIN_GAIN:  lin_gain = data & 32'h7FFFF;
      REG_MIN_LIN:   min_lin  = data & 32'h3FFFF;
      default:       max_lin  = data & 32'h3FFFF;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || s_tvalid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // words: id, w, h, then the homography column by column
  task automatic send_message(longint id, int len, logic [31:0] h[9], logic [31:0] w,
                              logic [31:0] ht);
    logic [31:0] words[15];
    words[0] = 32'((id <<< FRAC_BITS) | $urandom_range(16'hFFFF));
    if (id < 0) words[0] = 32'((id <<< FRAC_BITS) + 1);
    words[1] = w;
    words[2] = ht;
    for (int i = 0; i < 9; i++) words[3 + i] = h[i];
    for (int i = 12; i < 15; i++) words[i] = $urandom;
    for (int i = 0; i < len; i++) push(CMD_WORD, words[i], i == len - 1);
  endtask

  task automatic random_message();
    logic [31:0] h[9];
    int kind, len;
    longint id;
    kind = $urandom_range(99);
    foreach (h[i]) h[i] = $urandom;
    if (kind < 75) begin
      // well-formed: denominator mostly near one, some zero, random or tiny; numerator spread around the image
      h[0] = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
      h[3] = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
      h[6] = $signed($urandom_range(0, 1600)) - 400 <<< FRAC_BITS;
      h[6] = h[6] | $urandom_range(16'hFFFF);
      h[2] = $signed($urandom_range(0, 512)) - 256;
      h[5] = $signed($urandom_range(0, 512)) - 256;
      case ($urandom_range(9))
        0: begin h[2] = 0; h[5] = 0; h[8] = 0; end
        1: h[8] = $urandom;
        2: h[8] = $urandom_range(1, 16);
        default: h[8] = (1 << 16) + $signed($urandom_range(0, 8192)) - 4096;
      endcase
    end
    id = tgt_id;
    len = MSG_WORDS;
    if (kind >= 75 && kind < 83) id = $urandom_range(0, 255);
    if (kind >= 83 && kind < 86) id = -longint'($urandom_range(1, 300));
    if (kind >= 86 && kind < 92) len = $urandom_range(1, MSG_WORDS - 1);
    if (kind >= 92) len = $urandom_range(MSG_WORDS + 1, 15);
    if ($urandom_range(9) == 0) begin
      push(CMD_WORD, $urandom, 1'b0);
      push(CMD_EMPTY, $urandom, 1'($urandom_range(1)));
    end
    send_message(id, len, h, $urandom_range(0, 400 << 16), $urandom_range(0, 400 << 16));
  endtask

  initial begin
    logic [31:0] h[9];
    int sent;
    tgt_id = 3; ang_gain = 131; min_ang = 9830; max_ang = 32768;
    desired = 39322; lin_gain = 26214; min_lin = 3277; max_lin = 26214;
    left_rng = 0; right_rng = 0; wcount = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: range extremes, special messages, under reset settings
    push(CMD_LEFT, 32'h8000_0000, 1'b1);
    push(CMD_RIGHT, 32'h7FFF_FFFF, 1'b0);
    push(CMD_EMPTY, 32'hFFFF_FFFF, 1'b1);
    foreach (h[i]) h[i] = 0;
    h[0] = 1 << 16; h[4] = 1 << 16; h[8] = 1 << 16; h[6] = 320 << 16;
    push(CMD_LEFT, 2 << 16, 1'b0);
    push(CMD_RIGHT, 3 << 16, 1'b0);
    send_message(3, MSG_WORDS, h, 40 << 16, 30 << 16);     // centered: linear drive
    send_message(3, 3, h, 0, 0);                           // short message
    send_message(7, 1, h, 0, 0);                           // other id
    send_message(-3, MSG_WORDS, h, 0, 0);                  // negative id
    send_message(3, 15, h, 10 << 16, 10 << 16);            // long message
    h[8] = 0;
    send_message(3, MSG_WORDS, h, 10 << 16, 10 << 16);     // zero divisor
    h[8] = 1; h[6] = 32'h7FFF_FFFF;
    send_message(3, MSG_WORDS, h, 10 << 16, 10 << 16);     // huge projection
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < 8; r++) begin
        int unsigned val;
        int unsigned hi;
        hi = r == REG_TARGET_ID ? 255 : r == REG_ANG_GAIN ? 65536 :
             r == REG_DESIRED ? 4194304 : (r == REG_MIN_LIN || r == REG_MAX_LIN) ? 131072 :
             262144;
        if (phase == 0) val = hi;
        else if (phase == 1) val = 0;
        else val = $urandom_range(0, hi);
        if (phase > 1 && r == REG_ANG_GAIN) val = $urandom_range(0, 2000);
        if (phase > 1 && (r == REG_MIN_ANG || r == REG_MIN_LIN)) val = $urandom_range(0, 60000);
        if (phase == 7 && r == REG_TARGET_ID) val = hi;
        write_reg(cfg_reg_t'(r), val);
      end
      @(posedge clk);
      cfg_write <= 1'b0;
      no_gaps = phase == 3;
      sent = 0;
      while (sent < 95) begin
        int before_n;
        before_n = pending_items.size();
        case ($urandom_range(5))
          0: push(CMD_LEFT, $urandom_range(1) ? $urandom : $urandom_range(0, 8 << 16),
                  1'($urandom_range(1)));
          1: push(CMD_RIGHT, $urandom_range(1) ? $urandom : $urandom_range(0, 8 << 16),
                  1'($urandom_range(1)));
          default: random_message();
        endcase
        sent += pending_items.size() - before_n;
      end
      wait_idle();
    end
    no_gaps = 1'b0;

    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("homography_visual_follow_controller_unit regression: pass");
    end else begin
      $display("homography_visual_follow_controller_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/hvf_pkg.sv
design/hvf_divider.sv
design/hvf_core.sv
design/homography_visual_follow_controller_unit.sv
bench/homography_visual_follow_controller_unit_test.sv
